@@ hw/rtl/lifs_pkg.sv @@
// ----------------------------------------------------------------------------
// lifs_pkg
// Shared types and constants of the limited interface flux stencil.
// ----------------------------------------------------------------------------
`default_nettype none
package lifs_pkg;

  localparam int FRAC_W     = 16;
  localparam int VAL_W      = 32;
  localparam int SPD_W      = 31;
  localparam int CW_W       = 31;
  localparam int THETA_W    = 18;
  localparam int MIND_W     = 17;
  localparam int Q1_W       = FRAC_W + 1;
  localparam int DIV_NUM_W  = 51;
  localparam int DIV_DEN_W  = 46;
  localparam int DIV_SH_W   = DIV_DEN_W + FRAC_W;
  localparam int DIV_CNT_W  = 5;

  localparam logic [Q1_W-1:0] ONE_Q = Q1_W'(1) << FRAC_W;

  localparam logic [CW_W-1:0]    CW_RESET    = CW_W'(65536);
  localparam logic [THETA_W-1:0] THETA_RESET = THETA_W'(65536);
  localparam logic [MIND_W-1:0]  MIND_RESET  = '0;

  localparam logic [1:0] REG_CELL_WIDTH = 2'd0;
  localparam logic [1:0] REG_THETA      = 2'd1;
  localparam logic [1:0] REG_MIN_DISS   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_PHI,
    ST_PHI_WAIT,
    ST_KD,
    ST_KD_WAIT,
    ST_W,
    ST_M,
    ST_OUT
  } lifs_state_t;

  typedef struct packed {
    logic [CW_W-1:0]    cell_width;
    logic [THETA_W-1:0] theta;
    logic [MIND_W-1:0]  min_diss;
  } lifs_cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } lifs_div_req_t;

  typedef struct packed {
    logic            done;
    logic [Q1_W-1:0] quo;
  } lifs_div_rsp_t;

endpackage
`default_nettype wire

@@ hw/rtl/lifs_div.sv @@
// ----------------------------------------------------------------------------
// lifs_div
// Radix-2 restoring divider giving a 17-bit fixed-point quotient.
// ----------------------------------------------------------------------------
`default_nettype none
module lifs_div (
  input  wire                   clk,
  input  wire                   rst_n,
  input  lifs_pkg::lifs_div_req_t req,
  output lifs_pkg::lifs_div_rsp_t rsp
);

  logic                            busy_r;
  logic                            done_r;
  logic [lifs_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [lifs_pkg::DIV_NUM_W-1:0]  rem_r;
  logic [lifs_pkg::DIV_SH_W-1:0]   dsh_r;
  logic [lifs_pkg::Q1_W-1:0]       quo_r;
  logic [lifs_pkg::DIV_SH_W-1:0]   rem_ext;
  logic                            fits;

  assign rem_ext = lifs_pkg::DIV_SH_W'(rem_r);
  assign fits    = rem_ext >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= lifs_pkg::DIV_CNT_W'(lifs_pkg::FRAC_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      dsh_r <= {req.den, {lifs_pkg::FRAC_W{1'b0}}};
      quo_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= lifs_pkg::DIV_NUM_W'(rem_ext - dsh_r);
      end
      quo_r <= {quo_r[lifs_pkg::Q1_W-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

@@ hw/rtl/lifs_core.sv @@
// ----------------------------------------------------------------------------
// lifs_core
// Cell window, sequencer and datapath of the interface flux computation.
// ----------------------------------------------------------------------------
`default_nettype none
module lifs_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  lifs_pkg::lifs_cfg_t          cfg,
  input  wire                          in_fire,
  input  wire signed [31:0]            in_value,
  input  wire signed [31:0]            in_flux,
  input  wire [lifs_pkg::SPD_W-1:0]    in_speed,
  input  wire [lifs_pkg::SPD_W-1:0]    in_absorb,
  input  wire [lifs_pkg::SPD_W-1:0]    in_scatter,
  input  wire                          in_start,
  output logic                         idle,
  input  wire                          out_ready,
  output logic                         out_valid,
  output logic [31:0]                  out_flux,
  output logic                         out_saw,
  output logic                         out_sat
);

  lifs_pkg::lifs_state_t state_r, state_nxt;

  logic signed [31:0]             win_u_r [3];
  logic signed [31:0]             win_f_r [2];
  logic [lifs_pkg::SPD_W-1:0]     win_c_r [2];
  logic [lifs_pkg::SPD_W-1:0]     win_a_r [2];
  logic [lifs_pkg::SPD_W-1:0]     win_s_r [2];
  logic [1:0]                     fill_r;

  logic signed [32:0]             dup_r, duc_r, dum_r, fsum_r;
  logic [lifs_pkg::SPD_W-1:0]     cmx_r;
  logic [32:0]                    osum_r;
  logic [50:0]                    pn_r;
  logic [45:0]                    kd_r;
  logic [47:0]                    t_r;
  logic [lifs_pkg::Q1_W-1:0]      phi_r, diss_r, w_r;
  logic [48:0]                    m_r;
  logic                           saw_r;

  logic                           out_valid_r, out_saw_r, out_sat_r;
  logic [31:0]                    out_flux_r;

  logic                           produce;
  logic [32:0]                    mag_dup, mag_duc, mag_dum, lo;
  logic                           same_sign, opp_sign, phi_big, kd_big;
  logic [63:0]                    kd_prod, t_prod;
  logic [33:0]                    w_prod;
  logic [64:0]                    m_prod;
  logic signed [50:0]             num;
  logic signed [49:0]             half;
  logic                           half_hi, half_lo, load_out;
  lifs_pkg::lifs_div_req_t        div_req;
  lifs_pkg::lifs_div_rsp_t        div_rsp;

  assign produce = !in_start && (fill_r == 2'd3);

  assign mag_dup = dup_r[32] ? 33'(-dup_r) : 33'(dup_r);
  assign mag_duc = duc_r[32] ? 33'(-duc_r) : 33'(duc_r);
  assign mag_dum = dum_r[32] ? 33'(-dum_r) : 33'(dum_r);
  assign lo      = (mag_dum < mag_dup) ? mag_dum : mag_dup;

  assign same_sign = (duc_r != '0) && (dup_r != '0) && (dum_r != '0) &&
                     (dup_r[32] == duc_r[32]) && (dum_r[32] == duc_r[32]);
  assign opp_sign  = (duc_r != '0) && (dup_r != '0) && (dum_r != '0) &&
                     (dup_r[32] != duc_r[32]) && (dum_r[32] != duc_r[32]);
  assign phi_big   = {1'b0, pn_r[50:17]} >= {1'b0, 1'b0, mag_duc};
  assign kd_big    = kd_r > 46'(lifs_pkg::ONE_Q);

  assign kd_prod = 64'(osum_r) * 64'(cfg.cell_width);
  assign t_prod  = 64'(cmx_r) * 64'(mag_duc);
  assign w_prod  = 34'(diss_r) * 34'(lifs_pkg::ONE_Q - phi_r);
  assign m_prod  = 65'(t_r) * 65'(w_r);

  assign num  = duc_r[32] ? (51'(fsum_r) + 51'(m_r)) : (51'(fsum_r) - 51'(m_r));
  assign half = num[50:1];
  assign half_hi = !half[49] && (half[48:31] != '0);
  assign half_lo = half[49] && (half[48:31] != '1);
  assign load_out = (state_r == lifs_pkg::ST_OUT) && (!out_valid_r || out_ready);

  lifs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lifs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    div_req     = '0;
    case (state_r)
      lifs_pkg::ST_IDLE: begin
        if (in_fire && produce) begin
          state_nxt = lifs_pkg::ST_MUL;
        end
      end
      lifs_pkg::ST_MUL: begin
        state_nxt = lifs_pkg::ST_PHI;
      end
      lifs_pkg::ST_PHI: begin
        if (same_sign && !phi_big) begin
          div_req.start = 1'b1;
          div_req.num   = pn_r;
          div_req.den   = 46'(mag_duc);
          state_nxt     = lifs_pkg::ST_PHI_WAIT;
        end else begin
          state_nxt = lifs_pkg::ST_KD;
        end
      end
      lifs_pkg::ST_PHI_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = lifs_pkg::ST_KD;
        end
      end
      lifs_pkg::ST_KD: begin
        if (!saw_r && kd_big) begin
          div_req.start = 1'b1;
          div_req.num   = 51'(1) << (2 * lifs_pkg::FRAC_W);
          div_req.den   = kd_r;
          state_nxt     = lifs_pkg::ST_KD_WAIT;
        end else begin
          state_nxt = lifs_pkg::ST_W;
        end
      end
      lifs_pkg::ST_KD_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = lifs_pkg::ST_W;
        end
      end
      lifs_pkg::ST_W: begin
        state_nxt = lifs_pkg::ST_M;
      end
      lifs_pkg::ST_M: begin
        state_nxt = lifs_pkg::ST_OUT;
      end
      lifs_pkg::ST_OUT: begin
        if (load_out) begin
          state_nxt = lifs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lifs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      for (int i = 0; i < 3; i++) begin
        win_u_r[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        win_f_r[i] <= '0;
        win_c_r[i] <= '0;
        win_a_r[i] <= '0;
        win_s_r[i] <= '0;
      end
    end else if (in_fire) begin
      win_u_r[0] <= in_start ? 32'sd0 : win_u_r[1];
      win_u_r[1] <= in_start ? 32'sd0 : win_u_r[2];
      win_u_r[2] <= in_value;
      win_f_r[0] <= in_start ? 32'sd0 : win_f_r[1];
      win_f_r[1] <= in_flux;
      win_c_r[0] <= in_start ? '0 : win_c_r[1];
      win_c_r[1] <= in_speed;
      win_a_r[0] <= in_start ? '0 : win_a_r[1];
      win_a_r[1] <= in_absorb;
      win_s_r[0] <= in_start ? '0 : win_s_r[1];
      win_s_r[1] <= in_scatter;
      if (in_start) begin
        fill_r <= 2'd1;
      end else if (fill_r != 2'd3) begin
        fill_r <= fill_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      lifs_pkg::ST_IDLE: begin
        if (in_fire) begin
          dup_r  <= 33'(in_value) - 33'(win_u_r[2]);
          duc_r  <= 33'(win_u_r[2]) - 33'(win_u_r[1]);
          dum_r  <= 33'(win_u_r[1]) - 33'(win_u_r[0]);
          fsum_r <= 33'(win_f_r[0]) + 33'(win_f_r[1]);
          cmx_r  <= (win_c_r[0] > win_c_r[1]) ? win_c_r[0] : win_c_r[1];
          osum_r <= 33'(win_a_r[0]) + 33'(win_a_r[1]) +
                    33'(win_s_r[0]) + 33'(win_s_r[1]);
        end
      end
      lifs_pkg::ST_MUL: begin
        pn_r <= 51'(cfg.theta) * 51'(lo);
        kd_r <= kd_prod[63:18];
        t_r  <= t_prod[63:16];
      end
      lifs_pkg::ST_PHI: begin
        saw_r <= opp_sign;
        phi_r <= (same_sign && phi_big) ? lifs_pkg::ONE_Q : '0;
      end
      lifs_pkg::ST_PHI_WAIT: begin
        if (div_rsp.done) begin
          phi_r <= (div_rsp.quo > lifs_pkg::ONE_Q) ? lifs_pkg::ONE_Q : div_rsp.quo;
        end
      end
      lifs_pkg::ST_KD: begin
        diss_r <= lifs_pkg::ONE_Q;
      end
      lifs_pkg::ST_KD_WAIT: begin
        if (div_rsp.done) begin
          diss_r <= (div_rsp.quo < cfg.min_diss) ? cfg.min_diss : div_rsp.quo;
        end
      end
      lifs_pkg::ST_W: begin
        w_r <= w_prod[32:16];
      end
      lifs_pkg::ST_M: begin
        m_r <= m_prod[64:16];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_saw_r <= saw_r;
      out_sat_r <= half_hi || half_lo;
      if (half_hi) begin
        out_flux_r <= 32'h7fff_ffff;
      end else if (half_lo) begin
        out_flux_r <= 32'h8000_0000;
      end else begin
        out_flux_r <= half[31:0];
      end
    end
  end

  assign idle      = (state_r == lifs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_flux  = out_flux_r;
  assign out_saw   = out_saw_r;
  assign out_sat   = out_sat_r;

endmodule
`default_nettype wire

@@ hw/rtl/limited_interface_flux_stencil_top.sv @@
// ----------------------------------------------------------------------------
// limited_interface_flux_stencil_top
// Minmod flux-limited numerical flux along one grid line, Q16.16.
// ----------------------------------------------------------------------------
// Cells stream in one word at a time; once three cells of a line are held, each
// new cell yields the limited flux at the interface between the middle two of the last four.
// A word that starts a result occupies the block through the accept, multiply,
// limiter, dissipation and output steps; one shared radix-2 divider computes
// the limiter ratio and then the dissipation factor, and a division is skipped
// when its outcome is already known. A word that yields no result is taken in
// while the block stays idle. A finished result sits in the output register
// while the next word is taken in.
`default_nettype none
module limited_interface_flux_stencil_top (
  input  wire          clk,
  input  wire          rst_n,
  // tdata: cell_value[31:0], cell_flux[63:32], cell_speed[94:64],
  //        absorption[125:95], scattering[156:126], zero[159:157]
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire [159:0]  in_tdata,
  // tuser: line_start[0]
  input  wire          in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // tdata: interface_flux[31:0]
  output logic [31:0]  out_tdata,
  // tuser: sawtooth_seen[0], saturated[1]
  output logic [1:0]   out_tuser,
  input  wire          cfg_psel,
  input  wire          cfg_penable,
  input  wire          cfg_pwrite,
  input  wire [3:0]    cfg_paddr,
  input  wire [31:0]   cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  lifs_pkg::lifs_cfg_t cfg_r;
  logic                cfg_wr;
  logic                idle;
  logic                in_fire;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_width <= lifs_pkg::CW_RESET;
      cfg_r.theta      <= lifs_pkg::THETA_RESET;
      cfg_r.min_diss   <= lifs_pkg::MIND_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        lifs_pkg::REG_CELL_WIDTH: cfg_r.cell_width <= cfg_pwdata[30:0];
        lifs_pkg::REG_THETA:      cfg_r.theta      <= cfg_pwdata[17:0];
        lifs_pkg::REG_MIN_DISS:   cfg_r.min_diss   <= cfg_pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      lifs_pkg::REG_CELL_WIDTH: cfg_prdata = 32'(cfg_r.cell_width);
      lifs_pkg::REG_THETA:      cfg_prdata = 32'(cfg_r.theta);
      lifs_pkg::REG_MIN_DISS:   cfg_prdata = 32'(cfg_r.min_diss);
      default:                  cfg_prdata = '0;
    endcase
  end

  assign in_tready = idle;
  assign in_fire   = in_tvalid && idle;

  lifs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_fire    (in_fire),
    .in_value   (in_tdata[31:0]),
    .in_flux    (in_tdata[63:32]),
    .in_speed   (in_tdata[94:64]),
    .in_absorb  (in_tdata[125:95]),
    .in_scatter (in_tdata[156:126]),
    .in_start   (in_tuser),
    .idle       (idle),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_flux   (out_tdata),
    .out_saw    (out_tuser[0]),
    .out_sat    (out_tuser[1])
  );

endmodule
`default_nettype wire
